FILE: rtl/plr_pkg.sv
// shared types and constants for the positional list engine
package plr_pkg;

    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 7;

    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
        logic wr;
        logic rd;
    } t_cell_ctrl;

    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [LEN_W-1:0]  length;
    } t_meta;

endpackage

FILE: rtl/positional_list_engine.sv
// top level: command decode, element count and the row of list slots
// Ordered list of up to CAPACITY elements addressed by 1-based position.
// A command is taken at any edge where start is high; busy stays low, so
// one command can be issued every cycle. The list itself updates in the
// cycle the command is taken: each slot compares its index with the
// position and shifts toward its neighbor in parallel. Read data is then
// gathered through a registered or-tree of log2(CAPACITY) levels, so the
// result strobe o_valid follows the command by 1 + log2(CAPACITY) cycles
// (7 at the default of 64), results come out in command order and must be
// captured in their single strobe cycle since they cannot be held off.
// Slots beyond the current length hold stale data; no clearing pass runs.
module positional_list_engine #(
    parameter int CAPACITY      = plr_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = plr_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [plr_pkg::CMD_W-1:0]     i_command,
    input  logic [plr_pkg::POS_W-1:0]     i_position,
    input  logic [plr_pkg::DATA_W-1:0]    i_write_value,
    output logic                          o_valid,
    output logic [plr_pkg::STATUS_W-1:0]  o_status,
    output logic [plr_pkg::DATA_W-1:0]    o_read_value,
    output logic [plr_pkg::LEN_W-1:0]     o_length
);

    localparam int EW  = ELEMENT_WIDTH;
    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = ((CW > plr_pkg::POS_W) ? CW : plr_pkg::POS_W) + 1;
    localparam int LAT = IW + 1;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                w_accept;
    logic [XW-1:0]       w_pos;
    logic [XW-1:0]       w_cnt;
    logic                w_pos_zero;
    logic [IW-1:0]       w_idx;
    logic [EW-1:0]       w_wval;
    plr_pkg::t_cell_ctrl w_ctrl;
    plr_pkg::t_status    w_status;
    plr_pkg::t_meta      r_meta;
    plr_pkg::t_meta      w_meta_out;
    logic [EW-1:0]       w_value [CAPACITY];
    logic [EW-1:0]       w_tap   [CAPACITY];
    logic [EW-1:0]       w_rdata;

    assign busy       = 1'b0;
    assign w_accept   = start && !busy;
    assign w_pos      = XW'(i_position);
    assign w_cnt      = XW'(r_count);
    assign w_pos_zero = (i_position == '0);
    assign w_idx      = IW'(w_pos - XW'(1));
    assign w_wval     = EW'(i_write_value);

    always_comb begin
        n_count  = r_count;
        w_ctrl   = '0;
        w_status = plr_pkg::ST_DONE;
        unique case (plr_pkg::t_cmd'(i_command))
            plr_pkg::CMD_INSERT: begin
                if (w_pos_zero || (w_pos > w_cnt + XW'(1))) begin
                    w_status = plr_pkg::ST_RANGE;
                end else if (w_cnt >= XW'(CAPACITY)) begin
                    w_status = plr_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + CW'(1);
                end
            end
            plr_pkg::CMD_DELETE: begin
                if (w_pos_zero || (w_pos > w_cnt)) begin
                    w_status = plr_pkg::ST_RANGE;
                end else begin
                    w_ctrl.del = w_accept;
                    w_ctrl.rd  = w_accept;
                    n_count    = r_count - CW'(1);
                end
            end
            plr_pkg::CMD_READ: begin
                if (w_pos_zero || (w_pos > w_cnt)) begin
                    w_status = plr_pkg::ST_RANGE;
                end else begin
                    w_ctrl.rd = w_accept;
                end
            end
            plr_pkg::CMD_WRITE: begin
                if (w_pos_zero || (w_pos > w_cnt)) begin
                    w_status = plr_pkg::ST_RANGE;
                end else begin
                    w_ctrl.wr = w_accept;
                end
            end
            plr_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                w_status = plr_pkg::ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_meta  <= '0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_meta.valid  <= w_accept;
            r_meta.status <= w_status;
            r_meta.length <= plr_pkg::LEN_W'(n_count);
        end
    end

    genvar c;
    generate
        for (c = 0; c < CAPACITY; c++) begin : g_cell
            logic [EW-1:0] w_left;
            logic [EW-1:0] w_right;
            if (c == 0) begin : g_first
                assign w_left = w_value[c];
            end else begin : g_mid_l
                assign w_left = w_value[c-1];
            end
            if (c == CAPACITY - 1) begin : g_last
                assign w_right = w_value[c];
            end else begin : g_mid_r
                assign w_right = w_value[c+1];
            end
            plr_cell #(
                .EW    (EW),
                .IW    (IW),
                .INDEX (c)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_idx   (w_idx),
                .i_wval  (w_wval),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_value[c]),
                .o_tap   (w_tap[c])
            );
        end
    endgenerate

    plr_or_tree #(
        .EW (EW),
        .N  (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_taps  (w_tap),
        .i_meta  (r_meta),
        .o_meta  (w_meta_out),
        .o_value (w_rdata)
    );

    generate
        if (EW >= plr_pkg::DATA_W) begin : g_rd_wide
            assign o_read_value = w_rdata[plr_pkg::DATA_W-1:0];
        end else begin : g_rd_narrow
            assign o_read_value = plr_pkg::DATA_W'(w_rdata);
        end
    endgenerate

    assign o_valid  = w_meta_out.valid;
    assign o_status = w_meta_out.status;
    assign o_length = w_meta_out.length;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == plr_pkg::CMD_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the list");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LAT o_valid)
        else $error("result strobe missing after transfer");

    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == plr_pkg::ST_FULL))
            |-> (o_length == plr_pkg::LEN_W'(CAPACITY)))
        else $error("full status without full length");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != plr_pkg::ST_DONE)) |-> (o_read_value == '0))
        else $error("read data on failed command");
`endif

endmodule

FILE: rtl/plr_cell.sv
// one list slot: holds an element and shifts it with its neighbors
module plr_cell #(
    parameter int EW    = plr_pkg::ELEMENT_WIDTH_DEF,
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  logic                i_clk,
    input  plr_pkg::t_cell_ctrl i_ctrl,
    input  logic [IW-1:0]       i_idx,
    input  logic [EW-1:0]       i_wval,
    input  logic [EW-1:0]       i_left,
    input  logic [EW-1:0]       i_right,
    output logic [EW-1:0]       o_value,
    output logic [EW-1:0]       o_tap
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [EW-1:0] r_value;
    logic [EW-1:0] r_tap;
    logic          w_eq;
    logic          w_gt;

    assign w_eq = (MY_IDX == i_idx);
    assign w_gt = (MY_IDX > i_idx);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins && w_eq) begin
            r_value <= i_wval;
        end else if (i_ctrl.ins && w_gt) begin
            r_value <= i_left;
        end else if (i_ctrl.del && (w_eq || w_gt)) begin
            r_value <= i_right;
        end else if (i_ctrl.wr && w_eq) begin
            r_value <= i_wval;
        end
        r_tap <= (i_ctrl.rd && w_eq) ? r_value : '0;
    end

    assign o_value = r_value;
    assign o_tap   = r_tap;

endmodule

FILE: rtl/plr_or_tree.sv
// registered or-tree that gathers the selected slot, with result tag alongside
module plr_or_tree #(
    parameter int EW = plr_pkg::ELEMENT_WIDTH_DEF,
    parameter int N  = plr_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [EW-1:0]  i_taps [N],
    input  plr_pkg::t_meta i_meta,
    output plr_pkg::t_meta o_meta,
    output logic [EW-1:0]  o_value
);

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    logic [EW-1:0]  w_leaf [P];
    logic [EW-1:0]  r_node [1:P-1];
    plr_pkg::t_meta r_meta [L];

    // node j has children 2j and 2j+1, the bottom row reads the leaves
    genvar j;
    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < N) begin : g_used
                assign w_leaf[j] = i_taps[j];
            end else begin : g_pad
                assign w_leaf[j] = '0;
            end
        end
        for (j = 1; j < P; j++) begin : g_node
            if (2*j >= P) begin : g_bottom
                always_ff @(posedge i_clk) begin
                    r_node[j] <= w_leaf[2*j-P] | w_leaf[2*j-P+1];
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    r_node[j] <= r_node[2*j] | r_node[2*j+1];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < L; s++) begin
                r_meta[s] <= '0;
            end
        end else begin
            r_meta[0] <= i_meta;
            for (int s = 1; s < L; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
        end
    end

    assign o_meta  = r_meta[L-1];
    assign o_value = r_node[1];

endmodule
